/* src/tdpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int BIT_BITS    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam logic [VALUE_BITS-1:0] FIRST_PRIME = VALUE_BITS'(2);
    localparam logic [IDX_BITS-1:0]   LAST_SLOT   = IDX_BITS'(TABLE_DEPTH - 1);
    localparam logic [BIT_BITS-1:0]   TOP_BIT     = BIT_BITS'(VALUE_BITS - 1);

    typedef enum logic [1:0] {
        ST_COMPOSITE = 2'd0,
        ST_STORED    = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/trial_division_prime_table.sv */
// Trial-division prime table.
// Input channel: i_in_valid / o_in_stall carry one candidate word. The block
// takes a word only when idle; o_in_stall is high while a candidate is tested.
// Output channel: o_out_valid / i_out_stall carry one status and prime count
// word per candidate, held in an output register until taken.
// A candidate not above the last stored prime goes straight to the done state,
// which moves its result to the output register and returns to idle.
// Otherwise it is divided by every stored prime in turn on one restoring
// divider: for each prime, one table read, then one remainder bit a cycle,
// stopping at the first exact divisor. The result is loaded into the output
// register from the done state, which then returns to idle for the next word.
// The next candidate is taken once the result is in the output register,
// even while the receiver still stalls it; a new result waits in its final
// state until the output register is free.
// Reset (synchronous, active low) empties the table back to the single
// prime 2 and drops any pending result. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_table (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [tdpt_pkg::VALUE_BITS-1:0] i_candidate,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [1:0]                          o_status,
    output logic [tdpt_pkg::CNT_BITS-1:0]       o_prime_count
);
    import tdpt_pkg::*;

    logic [VALUE_BITS-1:0] r_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] r_rd_data;

    t_state                r_state, n_state;
    t_status               r_status, n_status;
    logic [VALUE_BITS-1:0] r_cand, n_cand;
    logic [VALUE_BITS-1:0] r_rem, n_rem;
    logic [IDX_BITS-1:0]   r_k, n_k;
    logic [BIT_BITS-1:0]   r_bit, n_bit;
    logic [IDX_BITS-1:0]   r_last_index, n_last_index;
    logic [VALUE_BITS-1:0] r_last_prime, n_last_prime;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [CNT_BITS-1:0]   r_out_count, n_out_count;

    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_idx;
    logic [VALUE_BITS-1:0] divisor;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS-1:0] rem_step;

    // entry zero is the fixed first prime
    assign divisor = (r_k == '0) ? FIRST_PRIME : r_rd_data;
    assign trial   = {r_rem, r_cand[r_bit]};
    assign rem_step = (trial >= {1'b0, divisor}) ?
                      VALUE_BITS'(trial - {1'b0, divisor}) : trial[VALUE_BITS-1:0];
    assign wr_idx  = IDX_BITS'(r_last_index + 1'b1);

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_cand       = r_cand;
        n_rem        = r_rem;
        n_k          = r_k;
        n_bit        = r_bit;
        n_last_index = r_last_index;
        n_last_prime = r_last_prime;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        wr_en        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cand = i_candidate;
                    if (i_candidate <= r_last_prime) begin
                        n_status = ST_IGNORED;
                        n_state  = S_DONE;
                    end else begin
                        n_k     = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_rem   = '0;
                n_bit   = TOP_BIT;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = rem_step;
                if (r_bit == '0) begin
                    if (rem_step == '0) begin
                        n_status = ST_COMPOSITE;
                        n_state  = S_DONE;
                    end else if (r_k == r_last_index) begin
                        n_status = (r_last_index == LAST_SLOT) ? ST_FULL : ST_STORED;
                        n_state  = S_DONE;
                    end else begin
                        n_k     = IDX_BITS'(r_k + 1'b1);
                        n_state = S_READ;
                    end
                end else begin
                    n_bit = BIT_BITS'(r_bit - 1'b1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = CNT_BITS'(r_last_index) + 1'b1;
                    if (r_status == ST_STORED) begin
                        wr_en        = 1'b1;
                        n_last_index = wr_idx;
                        n_last_prime = r_cand;
                        n_out_count  = CNT_BITS'(wr_idx) + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_index <= '0;
            r_last_prime <= FIRST_PRIME;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last_index <= n_last_index;
            r_last_prime <= n_last_prime;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_cand       <= n_cand;
        r_rem        <= n_rem;
        r_k          <= n_k;
        r_bit        <= n_bit;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= r_cand;
        end
        r_rd_data <= r_mem[r_k];
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_prime_count = r_out_count;

endmodule

`default_nettype wire

/* src/tdpt_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module tdpt_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [1:0]                      o_status,
    input wire logic [tdpt_pkg::CNT_BITS-1:0]   o_prime_count
);
    import tdpt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_prime_count))
        else $error("stalled result changed");

    // a taken candidate keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_prime_count != '0
            && o_prime_count <= CNT_BITS'(TABLE_DEPTH))
        else $error("prime count out of range");

    a_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_STORED |-> o_prime_count >= CNT_BITS'(2))
        else $error("stored prime with count below two");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_prime_count == CNT_BITS'(TABLE_DEPTH))
        else $error("full status with table not full");

endmodule

bind trial_division_prime_table tdpt_chk u_tdpt_chk (.*);

`default_nettype wire
